// ----- hdl/mwts_pkg.sv -----
// ============================================================================
// mwts_pkg
// Shared types, constants and tables for the mecanum wheel target solver.
// ============================================================================
package mwts_pkg;

    localparam int WHEEL_COUNT  = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;

    // CORDIC datapath: Q.14 velocities plus growth headroom
    localparam int X_W = 33;

    localparam logic signed [17:0] CORDIC_GAIN_Q16 = 18'sd39798;
    localparam logic signed [17:0] HALF_SQRT2_Q16  = 18'sd46341;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHASSIS_RADIUS   = 2'd0,
        CFG_INV_WHEEL_RADIUS = 2'd1,
        CFG_WHEEL_LIMIT      = 2'd2,
        CFG_POLARITY_MASK    = 2'd3
    } t_cfg_idx;

    localparam logic [14:0] RST_CHASSIS_RADIUS   = 15'd691;
    localparam logic [15:0] RST_INV_WHEEL_RADIUS = 16'd256;
    localparam logic [14:0] RST_WHEEL_LIMIT      = 15'd5120;
    localparam logic [3:0]  RST_POLARITY_MASK    = 4'd3;

    // bit w set: that term enters wheel w negated (vx always positive)
    localparam logic [WHEEL_COUNT-1:0] MIX_VY_NEG   = 4'b0101;
    localparam logic [WHEEL_COUNT-1:0] MIX_SPIN_NEG = 4'b0011;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic signed [X_W-1:0] atan_turn(input logic [3:0] idx);
        logic signed [X_W-1:0] val;
        case (idx)
            4'd0:    val = 33'sd536870912;
            4'd1:    val = 33'sd316933406;
            4'd2:    val = 33'sd167458907;
            4'd3:    val = 33'sd85004756;
            4'd4:    val = 33'sd42667331;
            4'd5:    val = 33'sd21354465;
            4'd6:    val = 33'sd10679838;
            4'd7:    val = 33'sd5340245;
            4'd8:    val = 33'sd2670163;
            4'd9:    val = 33'sd1335087;
            4'd10:   val = 33'sd667544;
            4'd11:   val = 33'sd333772;
            4'd12:   val = 33'sd166886;
            4'd13:   val = 33'sd83443;
            4'd14:   val = 33'sd41722;
            4'd15:   val = 33'sd20861;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/mecanum_wheel_target_solver.sv -----
// ============================================================================
// mecanum_wheel_target_solver
// Mecanum inverse kinematics: body command in, four wheel speed targets out.
// ============================================================================
// Fully pipelined: one command per clock when the output side is not
// stalled. The datapath is a quadrant fold, the 16-stage unrolled CORDIC
// yaw rotation and then gain, mix, wheel-radius and
// saturation stages, each at most one multiply deep. Valid bits travel
// with the data and each stage advances when the one after it is empty or
// advancing, so bubbles close up under back-pressure. Config registers are
// read live by the datapath; write them only with the pipeline empty.
// ============================================================================
module mecanum_wheel_target_solver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [mwts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mwts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [63:0]                    i_s_tdata,  // vel_x, vel_y, spin_rate, yaw_angle
    input  logic [1:0]                     i_s_tuser,  // link_ok, halt
    // wheel target stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [63:0]                    o_m_tdata   // wheel_one .. wheel_four
);

    localparam int NS     = 25;
    localparam int ST_CRD = mwts_pkg::CORDIC_STEPS;  // last CORDIC stage
    localparam int XW     = mwts_pkg::X_W;
    localparam int WC     = mwts_pkg::WHEEL_COUNT;

    // ---------------- config registers ----------------
    logic [14:0] r_cr;
    logic [15:0] r_iwr;
    logic [14:0] r_lim;
    logic [3:0]  r_pol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr  <= mwts_pkg::RST_CHASSIS_RADIUS;
            r_iwr <= mwts_pkg::RST_INV_WHEEL_RADIUS;
            r_lim <= mwts_pkg::RST_WHEEL_LIMIT;
            r_pol <= mwts_pkg::RST_POLARITY_MASK;
        end else if (i_cfg_we) begin
            case (mwts_pkg::t_cfg_idx'(i_cfg_idx))
                mwts_pkg::CFG_CHASSIS_RADIUS:   r_cr  <= i_cfg_data[14:0];
                mwts_pkg::CFG_INV_WHEEL_RADIUS: r_iwr <= i_cfg_data[15:0];
                mwts_pkg::CFG_WHEEL_LIMIT:      r_lim <= i_cfg_data[14:0];
                mwts_pkg::CFG_POLARITY_MASK:    r_pol <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-2:0] r_stop;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_stop[0] <= !i_s_tuser[0] || i_s_tuser[1];
        end
        for (int k = 1; k < NS - 1; k++) begin
            if (en[k]) begin
                r_stop[k] <= r_stop[k-1];
            end
        end
    end

    // ---------------- stage 0: quadrant fold, spin product ----------------
    logic signed [15:0] vx, vy, spin, theta, theta_adj;
    logic signed [29:0] vx_q, vy_q;
    logic signed [XW-1:0] x0, y0, z0;
    logic signed [31:0] n_spin;
    logic wrap;

    assign vx    = i_s_tdata[15:0];
    assign vy    = i_s_tdata[31:16];
    assign spin  = i_s_tdata[47:32];
    assign theta = i_s_tdata[63:48];
    assign wrap  = (theta > 16'sd16384) || (theta < -16'sd16384);
    assign theta_adj = wrap ? {~theta[15], theta[14:0]} : theta;
    assign vx_q  = {vx, 14'b0};
    assign vy_q  = {vy, 14'b0};
    assign x0    = wrap ? -XW'(vx_q) : XW'(vx_q);
    assign y0    = wrap ? -XW'(vy_q) : XW'(vy_q);
    assign z0    = XW'($signed({theta_adj, 16'b0}));
    assign n_spin = spin * $signed({1'b0, r_cr});

    logic signed [XW-1:0] r_cx   [ST_CRD+1];
    logic signed [XW-1:0] r_cy   [ST_CRD+1];
    logic signed [XW-1:0] r_cz   [ST_CRD];
    logic signed [31:0]   r_spin [ST_CRD+2];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cx[0]   <= x0;
            r_cy[0]   <= y0;
            r_cz[0]   <= z0;
            r_spin[0] <= n_spin;
        end
    end

    // ---------------- stages 1..16: CORDIC rotation ----------------
    for (genvar gi = 0; gi < ST_CRD; gi++) begin : g_cordic
        logic signed [XW-1:0] dx, dy;
        assign dx = r_cy[gi] >>> gi;
        assign dy = r_cx[gi] >>> gi;

        always_ff @(posedge i_clk) begin
            if (en[gi+1]) begin
                if (!r_cz[gi][XW-1]) begin
                    r_cx[gi+1] <= r_cx[gi] - dx;
                    r_cy[gi+1] <= r_cy[gi] + dy;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] + dx;
                    r_cy[gi+1] <= r_cy[gi] - dy;
                end
                r_spin[gi+1] <= r_spin[gi];
            end
        end

        // residual angle is not needed after the last step
        if (gi < ST_CRD - 1) begin : g_z
            logic signed [XW-1:0] at;
            assign at = mwts_pkg::atan_turn(4'(gi));

            always_ff @(posedge i_clk) begin
                if (en[gi+1]) begin
                    if (!r_cz[gi][XW-1]) begin
                        r_cz[gi+1] <= r_cz[gi] - at;
                    end else begin
                        r_cz[gi+1] <= r_cz[gi] + at;
                    end
                end
            end
        end
    end

    // ---------------- stage 17: gain multiply ----------------
    logic signed [50:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (en[ST_CRD+1]) begin
            r_px <= r_cx[ST_CRD] * mwts_pkg::CORDIC_GAIN_Q16;
            r_py <= r_cy[ST_CRD] * mwts_pkg::CORDIC_GAIN_Q16;
            r_spin[ST_CRD+1] <= r_spin[ST_CRD];
        end
    end

    // ---------------- stage 18: gain rounding ----------------
    logic signed [34:0] r_xr, r_yr;
    logic signed [37:0] r_sp;

    always_ff @(posedge i_clk) begin
        if (en[ST_CRD+2]) begin
            r_xr <= 35'((r_px + 51'sd32768) >>> 16);
            r_yr <= 35'((r_py + 51'sd32768) >>> 16);
            r_sp <= $signed({r_spin[ST_CRD+1], 6'b0});
        end
    end

    // ---------------- stages 19..24: per-wheel mix, scale, clamp ----------------
    logic signed [35:0] lim_s;
    logic [15:0] r_out [WC];

    assign lim_s = $signed({21'b0, r_lim});

    for (genvar gw = 0; gw < WC; gw++) begin : g_wheel
        logic signed [38:0] r_sum;
        logic signed [56:0] r_mix;
        logic signed [40:0] r_v;
        logic signed [57:0] r_t;
        logic signed [35:0] r_r;
        logic signed [38:0] t_y, t_s;
        logic signed [57:0] t_sel, t_add;

        assign t_y   = mwts_pkg::MIX_VY_NEG[gw]   ? -39'(r_yr) : 39'(r_yr);
        assign t_s   = mwts_pkg::MIX_SPIN_NEG[gw] ? -39'(r_sp) : 39'(r_sp);
        assign t_sel = r_pol[gw] ? ~r_t : r_t;
        assign t_add = r_pol[gw] ? 58'sd2097153 : 58'sd2097152;

        always_ff @(posedge i_clk) begin
            if (en[ST_CRD+3]) begin
                r_sum <= 39'(r_xr) + t_y + t_s;
            end
            if (en[ST_CRD+4]) begin
                r_mix <= r_sum * mwts_pkg::HALF_SQRT2_Q16;
            end
            if (en[ST_CRD+5]) begin
                r_v <= 41'((r_mix + 57'sd32768) >>> 16);
            end
            if (en[ST_CRD+6]) begin
                r_t <= r_v * $signed({1'b0, r_iwr});
            end
            if (en[ST_CRD+7]) begin
                r_r <= 36'((t_sel + t_add) >>> 22);
            end
            if (en[ST_CRD+8]) begin
                if (r_stop[ST_CRD+7]) begin
                    r_out[gw] <= '0;
                end else if (r_r > lim_s) begin
                    r_out[gw] <= 16'(lim_s);
                end else if (r_r < -lim_s) begin
                    r_out[gw] <= 16'(-lim_s);
                end else begin
                    r_out[gw] <= 16'(r_r);
                end
            end
        end
    end

    assign o_m_tdata = {r_out[3], r_out[2], r_out[1], r_out[0]};

endmodule

// ----- hdl/mwts_checker.sv -----
// ============================================================================
// mwts_checker
// Port-level checks for the mecanum wheel target solver, bound to the top.
// ============================================================================
module mwts_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mwts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mwts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            o_s_tready,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [63:0]                     o_m_tdata
);

    logic [14:0] r_lim;
    logic signed [15:0] lim_p, lim_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= mwts_pkg::RST_WHEEL_LIMIT;
        end else if (i_cfg_we &&
                     mwts_pkg::t_cfg_idx'(i_cfg_idx) == mwts_pkg::CFG_WHEEL_LIMIT) begin
            r_lim <= i_cfg_data[14:0];
        end
    end

    assign lim_p = $signed({1'b0, r_lim});
    assign lim_n = -lim_p;

    // output register empties on reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a free or draining output stage leaves the input open
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tready || !o_m_tvalid) |-> o_s_tready)
        else $error("input stalled with output free");

    // stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output changed");

    // every wheel target within the saturation bound
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            $signed(o_m_tdata[15:0])  <= lim_p && $signed(o_m_tdata[15:0])  >= lim_n &&
            $signed(o_m_tdata[31:16]) <= lim_p && $signed(o_m_tdata[31:16]) >= lim_n &&
            $signed(o_m_tdata[47:32]) <= lim_p && $signed(o_m_tdata[47:32]) >= lim_n &&
            $signed(o_m_tdata[63:48]) <= lim_p && $signed(o_m_tdata[63:48]) >= lim_n)
        else $error("wheel target beyond limit");

endmodule

bind mecanum_wheel_target_solver mwts_checker u_mwts_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Testbench for mecanum_wheel_target_solver: body commands are streamed in,
// and each set of four wheel targets is checked against a cycle-free
// predictor of the yaw rotation, wheel mix, scaling, polarity and clamp.
// Directed extremes and stop cases come first, then random traffic over
// many register settings, with random back-pressure on both streams until the last batches.
// ============================================================================
module tb_top;

    localparam int        WATCHDOG_LIMIT = 2000;
    localparam int        DRAIN_CYCLES   = 40;
    localparam int        BATCHES        = 15;
    localparam int        BATCH_ITEMS    = 60;
    localparam longint    GAIN_Q16       = 39798;
    localparam longint    ROOT_HALF_Q16  = 46341;
    localparam logic [3:0] VY_NEG        = 4'b0101;
    localparam logic [3:0] SPIN_NEG      = 4'b0011;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // vel_x, vel_y, spin_rate, yaw_angle
    logic [1:0]  i_s_tuser;   // link_ok, halt
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;   // wheel_one, wheel_two, wheel_three, wheel_four

    logic [14:0] radius_q;
    logic [15:0] inv_radius_q;
    logic [14:0] limit_q;
    logic [3:0]  polarity_q;

    logic [63:0] expected_wheels [$];
    string       wheel_names [4] = '{"wheel_one", "wheel_two", "wheel_three", "wheel_four"};

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cmds_accepted;
    int stopped_cmds;
    int targets_checked;
    int settings_used;
    int quiet_cycles;

    mecanum_wheel_target_solver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint atan_step(input int idx);
        case (idx)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            default: return 20861;
        endcase
    endfunction

    function automatic logic [63:0] predict_wheels(input logic [63:0] cmd,
                                                   input logic [1:0] flags);
        longint theta, x, y, z, dx, dy, xr, yr, spin, sum, v, t, lim;
        logic [63:0] wheels;
        int i;
        int w;
        wheels = '0;
        if (!flags[0] || flags[1])
            return wheels;
        theta = longint'($signed(cmd[63:48]));
        x = longint'($signed(cmd[15:0])) * 16384;
        y = longint'($signed(cmd[31:16])) * 16384;
        // fold into +-quarter turn
        if (theta > 16384) begin
            theta = theta - 32768;
            x = -x;
            y = -y;
        end else if (theta < -16384) begin
            theta = theta + 32768;
            x = -x;
            y = -y;
        end
        z = theta * 65536;
        for (i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end
        xr = (x * GAIN_Q16 + 32768) >>> 16;
        yr = (y * GAIN_Q16 + 32768) >>> 16;
        spin = longint'($signed(cmd[47:32])) * longint'(radius_q) * 64;
        lim = longint'(limit_q);
        for (w = 0; w < 4; w++) begin
            sum = xr + (VY_NEG[w] ? -yr : yr) + (SPIN_NEG[w] ? -spin : spin);
            v = (sum * ROOT_HALF_Q16 + 32768) >>> 16;
            t = v * longint'(inv_radius_q);
            if (polarity_q[w])
                t = -t;
            t = (t + 2097152) >>> 22;
            if (t > lim)
                t = lim;
            if (t < -lim)
                t = -lim;
            wheels[16*w +: 16] = t[15:0];
        end
        return wheels;
    endfunction

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : wheel_monitor
        logic [63:0]        want;
        logic signed [15:0] want_w;
        logic signed [15:0] got_w;
        int                 w;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_wheels.push_back(predict_wheels(i_s_tdata, i_s_tuser));
                cmds_accepted++;
                if (!i_s_tuser[0] || i_s_tuser[1])
                    stopped_cmds++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_wheels.size() == 0) begin
                    $error("wheel target transfer with no command pending");
                    error_count++;
                end else begin
                    want = expected_wheels.pop_front();
                    targets_checked++;
                    for (w = 0; w < 4; w++) begin
                        want_w = want[16*w +: 16];
                        got_w  = o_m_tdata[16*w +: 16];
                        if (want_w !== got_w) begin
                            $error("%s: expected %0d, actual %0d",
                                   wheel_names[w], want_w, got_w);
                            error_count++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_tvalid && o_s_tready) ||
            (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAIL mecanum_wheel_target_solver");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy,
                            input logic [15:0] spin, input logic [15:0] yaw,
                            input logic link, input logic halt);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata  = {yaw, spin, vy, vx};
        i_s_tuser  = {halt, link};
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_wheels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input mwts_pkg::t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            mwts_pkg::CFG_CHASSIS_RADIUS:   radius_q     = val[14:0];
            mwts_pkg::CFG_INV_WHEEL_RADIUS: inv_radius_q = val;
            mwts_pkg::CFG_WHEEL_LIMIT:      limit_q      = val[14:0];
            mwts_pkg::CFG_POLARITY_MASK:    polarity_q   = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] radius, input logic [15:0] inv_radius,
                              input logic [15:0] limit, input logic [15:0] polarity);
        wait_idle();
        write_reg(mwts_pkg::CFG_CHASSIS_RADIUS, radius);
        write_reg(mwts_pkg::CFG_INV_WHEEL_RADIUS, inv_radius);
        write_reg(mwts_pkg::CFG_WHEEL_LIMIT, limit);
        write_reg(mwts_pkg::CFG_POLARITY_MASK, polarity);
        settings_used++;
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(4))
            0: return 16'($urandom_range(2047)) - 16'd1024;
            1: begin
                case ($urandom_range(4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_yaw();
        if ($urandom_range(3) == 0)
            return 16'(16384 * $urandom_range(3)) + 16'($urandom_range(4)) - 16'd2;
        return 16'($urandom_range(65535));
    endfunction

    task automatic test_kinematic_extremes();
        send_cmd(16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1, 1'b0);
        send_cmd(16'h7FFF, 16'h0000, 16'h0000, 16'd0,     1'b1, 1'b0);
        send_cmd(16'h8000, 16'h0000, 16'h0000, 16'd0,     1'b1, 1'b0);
        send_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'd16384, 1'b1, 1'b0);
        send_cmd(16'h0000, 16'h8000, 16'h0000, 16'd16385, 1'b1, 1'b0);
        send_cmd(16'h0100, 16'h0100, 16'h0000, 16'd49152, 1'b1, 1'b0);
        send_cmd(16'h0100, 16'hFF00, 16'h0000, 16'd49151, 1'b1, 1'b0);
        send_cmd(16'h0064, 16'h0032, 16'h0000, 16'd32768, 1'b1, 1'b0);
        send_cmd(16'h0000, 16'h0000, 16'h7FFF, 16'd0,     1'b1, 1'b0);
        send_cmd(16'h0000, 16'h0000, 16'h8000, 16'd65535, 1'b1, 1'b0);
        send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd32767, 1'b1, 1'b0);
        send_cmd(16'h8000, 16'h8000, 16'h8000, 16'd32769, 1'b1, 1'b0);
        send_cmd(16'h0001, 16'hFFFF, 16'h0001, 16'd1,     1'b1, 1'b0);
    endtask

    task automatic test_stop_inputs();
        send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1234, 1'b0, 1'b0);
        send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1234, 1'b1, 1'b1);
        send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1234, 1'b0, 1'b1);
        send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1234, 1'b1, 1'b0);
    endtask

    task automatic test_register_extremes();
        // zero clamp bound
        set_config(16'd691, 16'd256, 16'd0, 16'd3);
        send_cmd(16'h7FFF, 16'h1234, 16'h0800, 16'd5000, 1'b1, 1'b0);
        send_cmd(16'h8000, 16'hEDCC, 16'hF800, 16'd60000, 1'b1, 1'b0);
        // all-ones writes, upper bits beyond register width dropped
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(16'h0003, 16'hFFFD, 16'h0001, 16'd8192, 1'b1, 1'b0);
        send_cmd(16'h7FFF, 16'h8000, 16'h8000, 16'd40000, 1'b1, 1'b0);
        set_config(16'd0, 16'd0, 16'h7FFF, 16'd0);
        send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd100, 1'b1, 1'b0);
    endtask

    task automatic test_random_commands();
        int b;
        int n;
        logic link;
        logic halt;
        for (b = 0; b < BATCHES; b++) begin
            if (b == 5) begin
                send_idle_pct = 62;
                recv_idle_pct = 38;
            end else if (b == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (b)
                3:  set_config(16'd0, 16'd0, 16'd0, 16'd0);
                7:  set_config(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hF);
                11: set_config(16'd691, 16'd256, 16'd5120, 16'd3);
                default: set_config(
                    $urandom_range(1) ? 16'($urandom_range(1500)) : 16'($urandom_range(65535)),
                    $urandom_range(1) ? 16'($urandom_range(100, 700)) : 16'($urandom_range(65535)),
                    $urandom_range(1) ? 16'($urandom_range(8000)) : 16'($urandom_range(65535)),
                    16'($urandom_range(65535)));
            endcase
            for (n = 0; n < BATCH_ITEMS; n++) begin
                if ($urandom_range(99) < 82) begin
                    link = 1'b1;
                    halt = 1'b0;
                end else begin
                    link = 1'($urandom_range(1));
                    halt = link ? 1'b1 : 1'($urandom_range(1));
                end
                send_cmd(rand_vel(), rand_vel(), rand_vel(), rand_yaw(), link, halt);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = mwts_pkg::CFG_CHASSIS_RADIUS;
        i_cfg_data      = '0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = '0;
        radius_q        = mwts_pkg::RST_CHASSIS_RADIUS;
        inv_radius_q    = mwts_pkg::RST_INV_WHEEL_RADIUS;
        limit_q         = mwts_pkg::RST_WHEEL_LIMIT;
        polarity_q      = mwts_pkg::RST_POLARITY_MASK;
        send_idle_pct   = 38;
        recv_idle_pct   = 62;
        error_count     = 0;
        cmds_accepted   = 0;
        stopped_cmds    = 0;
        targets_checked = 0;
        settings_used   = 1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_kinematic_extremes();
        test_stop_inputs();
        test_register_extremes();
        test_random_commands();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_wheels.size() != 0) begin
            $error("%0d wheel target sets never arrived", expected_wheels.size());
            error_count++;
        end
        $display("Ran %0d commands (%0d stopped) across %0d register settings",
                 cmds_accepted, stopped_cmds, settings_used);
        $display("Checked %0d wheel target sets, %0d mismatches", targets_checked, error_count);
        if (error_count == 0) begin
            $display("PASS mecanum_wheel_target_solver");
        end else begin
            $display("FAIL mecanum_wheel_target_solver");
        end
        $finish;
    end

endmodule

// ----- mecanum_wheel_target_solver.f -----
hdl/mwts_pkg.sv
hdl/mecanum_wheel_target_solver.sv
hdl/mwts_checker.sv
dv/tb_top.sv
